/* rtl/core/fgse_pkg.sv */
// ----------------------------------------------------------------------------
// fgse_pkg
// Shared types and codes of the fixed-gain state estimator core: item and
// result words, coefficient matrix codes and the control word that the
// microcode sequencer hands to the datapath.
// ----------------------------------------------------------------------------
package fgse_pkg;

  localparam int DIM   = 4;
  localparam int IDX_W = 2;
  localparam int CNT_W = 3;
  localparam int CFG_W = 3;

  localparam int MAX_STATES = 4;
  localparam int MAX_INPUTS = 4;
  localparam int MAX_MEAS   = 4;

  localparam int COEF_DEPTH = 64;
  localparam int COEF_AW    = 6;

  typedef enum logic [1:0] {
    ACT_PREDICT = 2'd0,
    ACT_UPDATE  = 2'd1,
    ACT_WRITE   = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_STATES = 2'd0,
    REG_INPUTS = 2'd1,
    REG_MEAS   = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    MAT_A = 2'd0,
    MAT_B = 2'd1,
    MAT_C = 2'd2,
    MAT_L = 2'd3
  } mat_t;

  typedef enum logic [1:0] {
    OPND_EST   = 2'd0,
    OPND_VEC   = 2'd1,
    OPND_INNOV = 2'd2
  } opnd_t;

  typedef enum logic [1:0] {
    ACC_KEEP = 2'd0,
    ACC_ZERO = 2'd1,
    ACC_VEC  = 2'd2,
    ACC_EST  = 2'd3
  } acc_init_t;

  typedef enum logic [1:0] {
    STORE_NONE  = 2'd0,
    STORE_NEXT  = 2'd1,
    STORE_INNOV = 2'd2
  } store_t;

  typedef enum logic [1:0] {
    LIM_N = 2'd0,
    LIM_P = 2'd1,
    LIM_M = 2'd2
  } lim_sel_t;

  typedef enum logic [1:0] {
    FIN_COMMIT = 2'd0,
    FIN_CLEAR  = 2'd1,
    FIN_WRITE  = 2'd2
  } fin_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] elem0;
    logic signed [31:0] elem1;
    logic signed [31:0] elem2;
    logic signed [31:0] elem3;
    logic [1:0]         coef_matrix;
    logic [1:0]         coef_row;
    logic [1:0]         coef_col;
    logic signed [31:0] coef_value;
  } item_t;

  typedef struct packed {
    logic signed [31:0] est0;
    logic signed [31:0] est1;
    logic signed [31:0] est2;
    logic signed [31:0] est3;
    logic               saturated;
  } result_t;

  // Clamped sizes in use.
  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] p;
    logic [CNT_W-1:0] m;
  } sizes_t;

  // Control from the sequencer to the datapath, valid for one cycle.
  typedef struct packed {
    logic             issue;
    mat_t             mat;
    opnd_t            opnd;
    logic             sub;
    acc_init_t        acc_init;
    store_t           store;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic             done;
    fin_t             fin_op;
  } seq_ctl_t;

endpackage

/* rtl/core/fixed_gain_state_estimator_core.sv */
// ----------------------------------------------------------------------------
// fixed_gain_state_estimator_core
// Fixed-gain observer: predict x = A*x + B*u, update x = x + L*(y - C*x),
// coefficient load and clear, in Q16.16 with a 64-bit accumulator.
// ----------------------------------------------------------------------------
//   channel   signals                                  moves
//   item      item_valid, item_ready, item             one command word in
//   result    result_valid, result_ready, result       one estimate word out
//   cfg       cfg_valid, cfg_ready, cfg_index, cfg_data  one size register
//
// The single shared multiplier is fed one coefficient per cycle from the
// RAM read port, so the run of a predict or update word grows with the
// clamped sizes n, p and m; a write or clear word runs its final step only.
// Reset zeroes the estimate and sets all sizes to four; coefficients are
// undefined until loaded. A new word is taken while the previous result
// waits; the last step stalls only if the result register is still full.
// ----------------------------------------------------------------------------
module fixed_gain_state_estimator_core import fgse_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  item_t            item,
  output logic             result_valid,
  input  logic             result_ready,
  output result_t          result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [CFG_W-1:0] states_used;
  logic [CFG_W-1:0] inputs_used;
  logic [CFG_W-1:0] meas_used;
  sizes_t           sizes;
  logic             busy;
  logic             start;
  logic             out_free;
  seq_ctl_t         ctl;

  assign cfg_ready  = 1'b1;
  assign item_ready = !busy;
  assign start      = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      states_used <= CFG_W'(MAX_STATES);
      inputs_used <= CFG_W'(MAX_INPUTS);
      meas_used   <= CFG_W'(MAX_MEAS);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_STATES: states_used <= cfg_data;
        REG_INPUTS: inputs_used <= cfg_data;
        REG_MEAS:   meas_used   <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Out-of-range sizes are clamped to the supported span.
  always_comb begin
    if (states_used == '0) begin
      sizes.n = CNT_W'(1);
    end else if (states_used > CFG_W'(MAX_STATES)) begin
      sizes.n = CNT_W'(MAX_STATES);
    end else begin
      sizes.n = states_used;
    end
    if (inputs_used > CFG_W'(MAX_INPUTS)) begin
      sizes.p = CNT_W'(MAX_INPUTS);
    end else begin
      sizes.p = inputs_used;
    end
    if (meas_used == '0) begin
      sizes.m = CNT_W'(1);
    end else if (meas_used > CFG_W'(MAX_MEAS)) begin
      sizes.m = CNT_W'(MAX_MEAS);
    end else begin
      sizes.m = meas_used;
    end
  end

  fgse_useq u_useq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .action   (action_t'(item.action)),
    .sizes    (sizes),
    .out_free (out_free),
    .busy     (busy),
    .ctl      (ctl)
  );

  fgse_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item_in      (item),
    .ctl          (ctl),
    .out_free     (out_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

/* rtl/core/fgse_ram.sv */
// ----------------------------------------------------------------------------
// fgse_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fgse_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/fgse_useq.sv */
// ----------------------------------------------------------------------------
// fgse_useq
// Microcode sequencer: a step counter walks a read-only program, with
// repeat steps for the inner multiply-accumulate loops and conditional
// jumps for the row loops.
// ----------------------------------------------------------------------------
module fgse_useq import fgse_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  action_t  action,
  input  sizes_t   sizes,
  input  logic     out_free,
  output logic     busy,
  output seq_ctl_t ctl
);

  localparam int PC_W = 5;

  localparam logic [PC_W-1:0] ENTRY_PREDICT = PC_W'(0);
  localparam logic [PC_W-1:0] ENTRY_UPDATE  = PC_W'(7);
  localparam logic [PC_W-1:0] ENTRY_WRITE   = PC_W'(16);
  localparam logic [PC_W-1:0] ENTRY_CLEAR   = PC_W'(17);

  typedef struct packed {
    acc_init_t       acc_init;
    logic            mac;
    mat_t            mat;
    opnd_t           opnd;
    logic            sub;
    lim_sel_t        lim;
    store_t          store;
    lim_sel_t        row_lim;
    logic [PC_W-1:0] target;
    logic            fin;
    fin_t            fin_op;
  } ucode_t;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'b01,
    SEQ_RUN  = 2'b10
  } seq_state_t;

  // The program. A mac step repeats while its column counter is below the
  // limit; a store step closes a row and jumps back while rows remain.
  function automatic ucode_t ucode(input logic [PC_W-1:0] addr);
    ucode_t w;
    w.acc_init = ACC_KEEP;
    w.mac      = 1'b0;
    w.mat      = MAT_A;
    w.opnd     = OPND_EST;
    w.sub      = 1'b0;
    w.lim      = LIM_N;
    w.store    = STORE_NONE;
    w.row_lim  = LIM_N;
    w.target   = '0;
    w.fin      = 1'b0;
    w.fin_op   = FIN_COMMIT;
    unique case (addr)
      // Predict: x = A*x + B*u
      PC_W'(0):  w.acc_init = ACC_ZERO;
      PC_W'(1):  begin
        w.mac = 1'b1; w.mat = MAT_A; w.opnd = OPND_EST; w.lim = LIM_N;
      end
      PC_W'(2):  begin
        w.mac = 1'b1; w.mat = MAT_B; w.opnd = OPND_VEC; w.lim = LIM_P;
      end
      PC_W'(3):  ;
      PC_W'(4):  ;
      PC_W'(5):  begin
        w.store = STORE_NEXT; w.row_lim = LIM_N; w.target = PC_W'(0);
      end
      PC_W'(6):  begin
        w.fin = 1'b1; w.fin_op = FIN_COMMIT;
      end
      // Update: innovation rows, then correction rows
      PC_W'(7):  w.acc_init = ACC_VEC;
      PC_W'(8):  begin
        w.mac = 1'b1; w.mat = MAT_C; w.opnd = OPND_EST; w.sub = 1'b1;
        w.lim = LIM_N;
      end
      PC_W'(9):  ;
      PC_W'(10): begin
        w.store = STORE_INNOV; w.row_lim = LIM_M; w.target = PC_W'(7);
      end
      PC_W'(11): w.acc_init = ACC_EST;
      PC_W'(12): begin
        w.mac = 1'b1; w.mat = MAT_L; w.opnd = OPND_INNOV; w.lim = LIM_M;
      end
      PC_W'(13): ;
      PC_W'(14): begin
        w.store = STORE_NEXT; w.row_lim = LIM_N; w.target = PC_W'(11);
      end
      PC_W'(15): begin
        w.fin = 1'b1; w.fin_op = FIN_COMMIT;
      end
      PC_W'(16): begin
        w.fin = 1'b1; w.fin_op = FIN_WRITE;
      end
      PC_W'(17): begin
        w.fin = 1'b1; w.fin_op = FIN_CLEAR;
      end
      default: begin
        w.fin = 1'b1; w.fin_op = FIN_COMMIT;
      end
    endcase
    return w;
  endfunction

  seq_state_t       state;
  logic [PC_W-1:0]  pc;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] j;

  ucode_t           uw;
  logic [CNT_W-1:0] lim_j;
  logic [CNT_W-1:0] lim_i;
  logic             run;
  logic             j_more;
  logic             i_more;
  logic [PC_W-1:0]  entry;

  function automatic logic [CNT_W-1:0] pick(input lim_sel_t s, input sizes_t z);
    logic [CNT_W-1:0] r;
    unique case (s)
      LIM_N:   r = z.n;
      LIM_P:   r = z.p;
      LIM_M:   r = z.m;
      default: r = z.n;
    endcase
    return r;
  endfunction

  always_comb begin
    uw     = ucode(pc);
    run    = (state == SEQ_RUN);
    lim_j  = pick(uw.lim, sizes);
    lim_i  = pick(uw.row_lim, sizes);
    j_more = (j < lim_j);
    i_more = ((i + CNT_W'(1)) < lim_i);
    unique case (action)
      ACT_PREDICT: entry = ENTRY_PREDICT;
      ACT_UPDATE:  entry = ENTRY_UPDATE;
      ACT_WRITE:   entry = ENTRY_WRITE;
      ACT_CLEAR:   entry = ENTRY_CLEAR;
      default:     entry = ENTRY_CLEAR;
    endcase
  end

  always_comb begin
    ctl.issue    = run && uw.mac && j_more;
    ctl.mat      = uw.mat;
    ctl.opnd     = uw.opnd;
    ctl.sub      = uw.sub;
    ctl.acc_init = run ? uw.acc_init : ACC_KEEP;
    ctl.store    = run ? uw.store : STORE_NONE;
    ctl.i        = i[IDX_W-1:0];
    ctl.j        = j[IDX_W-1:0];
    ctl.done     = run && uw.fin && out_free;
    ctl.fin_op   = uw.fin_op;
  end

  assign busy = run;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      pc    <= '0;
      i     <= '0;
      j     <= '0;
    end else begin
      unique case (state)
        SEQ_IDLE: begin
          if (start) begin
            state <= SEQ_RUN;
            pc    <= entry;
            i     <= '0;
            j     <= '0;
          end
        end
        SEQ_RUN: begin
          if (uw.mac) begin
            if (j_more) begin
              j <= j + CNT_W'(1);
            end else begin
              j  <= '0;
              pc <= pc + PC_W'(1);
            end
          end else if (uw.store != STORE_NONE) begin
            if (i_more) begin
              i  <= i + CNT_W'(1);
              pc <= uw.target;
            end else begin
              i  <= '0;
              pc <= pc + PC_W'(1);
            end
          end else if (uw.fin) begin
            if (out_free) begin
              state <= SEQ_IDLE;
            end
          end else begin
            pc <= pc + PC_W'(1);
          end
        end
        default: state <= SEQ_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/fgse_dpath.sv */
// ----------------------------------------------------------------------------
// fgse_dpath
// Datapath: coefficient RAM, one pipelined 32x32 multiplier, a 64-bit
// accumulator, the estimate, staging and innovation registers, and the
// result register.
// ----------------------------------------------------------------------------
module fgse_dpath import fgse_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  item_t    item_in,
  input  seq_ctl_t ctl,
  output logic     out_free,
  output logic     result_valid,
  input  logic     result_ready,
  output result_t  result
);

  item_t              item;
  logic signed [31:0] est   [DIM];
  logic signed [31:0] nxt   [DIM];
  logic signed [31:0] innov [DIM];
  logic signed [31:0] vec   [DIM];
  logic signed [31:0] est_new [DIM];
  logic signed [63:0] acc;
  logic               sat;

  logic signed [31:0] opnd_sel;
  logic signed [31:0] opnd_q;
  logic               s1_valid;
  logic               s1_sub;
  logic signed [63:0] prod;
  logic               s2_valid;
  logic               s2_sub;
  logic signed [63:0] prod_sh;

  logic [31:0]        coef_q;
  logic               coef_we;
  logic [COEF_AW-1:0] coef_waddr;
  logic [COEF_AW-1:0] coef_raddr;

  logic               acc_ovf;
  logic signed [31:0] acc_sat;

  assign vec[0] = item.elem0;
  assign vec[1] = item.elem1;
  assign vec[2] = item.elem2;
  assign vec[3] = item.elem3;

  assign coef_we    = ctl.done && (ctl.fin_op == FIN_WRITE);
  assign coef_waddr = {item.coef_matrix, item.coef_row, item.coef_col};
  assign coef_raddr = {ctl.mat, ctl.i, ctl.j};

  fgse_ram #(
    .Width (32),
    .Depth (COEF_DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (item.coef_value),
    .raddr (coef_raddr),
    .rdata (coef_q)
  );

  always_comb begin
    unique case (ctl.opnd)
      OPND_EST:   opnd_sel = est[ctl.j];
      OPND_VEC:   opnd_sel = vec[ctl.j];
      OPND_INNOV: opnd_sel = innov[ctl.j];
      default:    opnd_sel = est[ctl.j];
    endcase
  end

  // An arithmetic shift of the exact product is the floor division by 2^16.
  assign prod_sh = prod >>> 16;

  // The accumulator fits 32 bits only if its top 33 bits agree.
  always_comb begin
    acc_ovf = !((acc[63:31] == '0) || (acc[63:31] == '1));
    if (!acc_ovf) begin
      acc_sat = acc[31:0];
    end else if (acc[63]) begin
      acc_sat = 32'sh8000_0000;
    end else begin
      acc_sat = 32'sh7FFF_FFFF;
    end
  end

  always_comb begin
    for (int k = 0; k < DIM; k++) begin
      unique case (ctl.fin_op)
        FIN_COMMIT: est_new[k] = nxt[k];
        FIN_CLEAR:  est_new[k] = '0;
        FIN_WRITE:  est_new[k] = est[k];
        default:    est_new[k] = est[k];
      endcase
    end
  end

  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
      for (int k = 0; k < DIM; k++) begin
        est[k] <= '0;
      end
    end else begin
      s1_valid <= ctl.issue;
      s2_valid <= s1_valid;
      if (ctl.done) begin
        result_valid <= 1'b1;
        for (int k = 0; k < DIM; k++) begin
          est[k] <= est_new[k];
        end
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    opnd_q <= opnd_sel;
    s1_sub <= ctl.sub;
    prod   <= $signed(coef_q) * opnd_q;
    s2_sub <= s1_sub;

    if (start) begin
      item <= item_in;
      sat  <= 1'b0;
      for (int k = 0; k < DIM; k++) begin
        nxt[k] <= est[k];
      end
    end else if (ctl.store != STORE_NONE) begin
      sat <= sat | acc_ovf;
      if (ctl.store == STORE_NEXT) begin
        nxt[ctl.i] <= acc_sat;
      end else begin
        innov[ctl.i] <= acc_sat;
      end
    end

    unique case (ctl.acc_init)
      ACC_ZERO: acc <= '0;
      ACC_VEC:  acc <= 64'(vec[ctl.i]);
      ACC_EST:  acc <= 64'(est[ctl.i]);
      ACC_KEEP: begin
        if (s2_valid) begin
          acc <= s2_sub ? (acc - prod_sh) : (acc + prod_sh);
        end
      end
      default: ;
    endcase

    if (ctl.done) begin
      result.est0      <= est_new[0];
      result.est1      <= est_new[1];
      result.est2      <= est_new[2];
      result.est3      <= est_new[3];
      result.saturated <= (ctl.fin_op == FIN_COMMIT) ? sat : 1'b0;
    end
  end

endmodule
